// ===== rtl/core/ps2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ps2a_pkg;

  // Special set 1 bytes
  localparam logic [7:0] PauseByte   = 8'hE1;
  localparam logic [7:0] ExtByte     = 8'hE0;
  localparam logic [7:0] PrtScMake   = 8'h2A;
  localparam logic [7:0] PrtScBreak  = 8'hB7;

  // Modifier key codes (low seven bits)
  localparam logic [6:0] CodeCtrl    = 7'h1D;
  localparam logic [6:0] CodeLShift  = 7'h2A;
  localparam logic [6:0] CodeRShift  = 7'h36;
  localparam logic [6:0] CodeLAlt    = 7'h38;

  // Bytes swallowed after pause and print screen
  localparam logic [2:0] PauseSkip   = 3'd5;
  localparam logic [2:0] PrtScSkip   = 3'd2;

  // Modifier register bit positions
  localparam int unsigned ModLCtrl   = 0;
  localparam int unsigned ModRCtrl   = 1;
  localparam int unsigned ModLAlt    = 2;
  localparam int unsigned ModLShift  = 3;
  localparam int unsigned ModRShift  = 4;

  typedef struct packed {
    logic [2:0] skip_count;
    logic       ext_prefix;
    logic [4:0] mods;
  } ps2a_state_t;

  // Modifier bit named by a key code
  function automatic logic [4:0] mod_for(input logic [6:0] code, input logic ext);
    logic [4:0] m;
    m = 5'b0;
    if (ext) begin
      if (code == CodeCtrl) m[ModRCtrl] = 1'b1;
    end else begin
      case (code)
        CodeCtrl:   m[ModLCtrl]  = 1'b1;
        CodeLShift: m[ModLShift] = 1'b1;
        CodeRShift: m[ModRShift] = 1'b1;
        CodeLAlt:   m[ModLAlt]   = 1'b1;
        default:    m = 5'b0;
      endcase
    end
    return m;
  endfunction

  // ASCII for a key code, plain or shifted; zero for unmapped keys
  function automatic logic [6:0] key_char(input logic [6:0] code, input logic sh);
    logic [6:0] c;
    case (code)
      7'h02: c = sh ? 7'h21 : 7'h31;
      7'h03: c = sh ? 7'h40 : 7'h32;
      7'h04: c = sh ? 7'h23 : 7'h33;
      7'h05: c = sh ? 7'h24 : 7'h34;
      7'h06: c = sh ? 7'h25 : 7'h35;
      7'h07: c = sh ? 7'h5E : 7'h36;
      7'h08: c = sh ? 7'h26 : 7'h37;
      7'h09: c = sh ? 7'h2A : 7'h38;
      7'h0A: c = sh ? 7'h28 : 7'h39;
      7'h0B: c = sh ? 7'h29 : 7'h30;
      7'h0C: c = sh ? 7'h5F : 7'h2D;
      7'h0D: c = sh ? 7'h2B : 7'h3D;
      7'h0E: c = 7'h08;
      7'h0F: c = 7'h09;
      7'h10: c = sh ? 7'h51 : 7'h71;
      7'h11: c = sh ? 7'h57 : 7'h77;
      7'h12: c = sh ? 7'h45 : 7'h65;
      7'h13: c = sh ? 7'h52 : 7'h72;
      7'h14: c = sh ? 7'h54 : 7'h74;
      7'h15: c = sh ? 7'h59 : 7'h79;
      7'h16: c = sh ? 7'h55 : 7'h75;
      7'h17: c = sh ? 7'h49 : 7'h69;
      7'h18: c = sh ? 7'h4F : 7'h6F;
      7'h19: c = sh ? 7'h50 : 7'h70;
      7'h1A: c = sh ? 7'h7B : 7'h5B;
      7'h1B: c = sh ? 7'h7D : 7'h5D;
      7'h1C: c = 7'h0A;
      7'h1E: c = sh ? 7'h41 : 7'h61;
      7'h1F: c = sh ? 7'h53 : 7'h73;
      7'h20: c = sh ? 7'h44 : 7'h64;
      7'h21: c = sh ? 7'h46 : 7'h66;
      7'h22: c = sh ? 7'h47 : 7'h67;
      7'h23: c = sh ? 7'h48 : 7'h68;
      7'h24: c = sh ? 7'h4A : 7'h6A;
      7'h25: c = sh ? 7'h4B : 7'h6B;
      7'h26: c = sh ? 7'h4C : 7'h6C;
      7'h27: c = sh ? 7'h3A : 7'h3B;
      7'h28: c = sh ? 7'h22 : 7'h27;
      7'h29: c = sh ? 7'h7E : 7'h60;
      7'h2B: c = sh ? 7'h7C : 7'h5C;
      7'h2C: c = sh ? 7'h5A : 7'h7A;
      7'h2D: c = sh ? 7'h58 : 7'h78;
      7'h2E: c = sh ? 7'h43 : 7'h63;
      7'h2F: c = sh ? 7'h56 : 7'h76;
      7'h30: c = sh ? 7'h42 : 7'h62;
      7'h31: c = sh ? 7'h4E : 7'h6E;
      7'h32: c = sh ? 7'h4D : 7'h6D;
      7'h33: c = sh ? 7'h3C : 7'h2C;
      7'h34: c = sh ? 7'h3E : 7'h2E;
      7'h35: c = sh ? 7'h3F : 7'h2F;
      7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      // keypad, same in both tables
      7'h47: c = 7'h37;
      7'h48: c = 7'h38;
      7'h49: c = 7'h39;
      7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34;
      7'h4C: c = 7'h35;
      7'h4D: c = 7'h36;
      7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31;
      7'h50: c = 7'h32;
      7'h51: c = 7'h33;
      7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ps2a_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2a_decode import ps2a_pkg::*; (
  input  wire ps2a_state_t state_i,
  input  wire logic [7:0]  scan_byte_i,
  output ps2a_state_t      state_o,
  output logic             emit_o,
  output logic [6:0]       char_o
);

  logic [6:0] code;
  logic [4:0] mod_bits;
  logic [4:0] mods_pressed;
  logic       shifted;

  assign code         = scan_byte_i[6:0];
  assign mod_bits     = mod_for(code, state_i.ext_prefix);
  assign mods_pressed = state_i.mods | mod_bits;
  assign shifted      = mods_pressed[ModLShift] | mods_pressed[ModRShift];

  // Byte handling in priority order: skip, pause, prefix, print screen,
  // release, press
  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    char_o  = 7'h00;
    if (state_i.skip_count != 3'd0) begin
      state_o.skip_count = state_i.skip_count - 3'd1;
    end else if (scan_byte_i == PauseByte) begin
      state_o.skip_count = PauseSkip;
    end else if (scan_byte_i == ExtByte) begin
      state_o.ext_prefix = 1'b1;
    end else if (state_i.ext_prefix &&
                 (scan_byte_i == PrtScMake || scan_byte_i == PrtScBreak)) begin
      state_o.skip_count = PrtScSkip;
      state_o.ext_prefix = 1'b0;
    end else if (scan_byte_i[7]) begin
      state_o.mods       = state_i.mods & ~mod_bits;
      state_o.ext_prefix = 1'b0;
    end else begin
      state_o.mods       = mods_pressed;
      state_o.ext_prefix = 1'b0;
      if (shifted) begin
        char_o = key_char(code, 1'b1);
      end else if (!state_i.ext_prefix) begin
        char_o = key_char(code, 1'b0);
      end
      emit_o = (char_o != 7'h00);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ps2_scancode_to_ascii.sv =====
// PS/2 scancode set 1 to ASCII decoder.
// Input channel: in_valid_i / in_ready_o carry one raw set 1 byte per item
// on scan_byte_i. Output channel: out_valid_o / out_ready_i carry one
// decoded character per item with the ctrl and alt status after that byte.
// Bytes that only change state (prefix, modifiers, releases, pause and
// print-screen tails, unmapped keys) produce no output item.
// Each byte is captured in an input register, decoded by a single pass of
// table lookup and flag update, and the character lands in the output
// register. One byte is taken every cycle while the receiver does not stall;
// the decode state loop (skip count, prefix, modifiers) runs through a
// single state register.
// While the receiver stalls the output register holds its item, the byte
// behind it waits in the input register, and in_ready_o drops once both
// are full.
// Reset clears the decode state, the modifiers and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ps2_scancode_to_ascii import ps2a_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] scan_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      character_o,
  output logic            ctrl_held_o,
  output logic            alt_held_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic [6:0]  char_q;
  logic        ctrl_q;
  logic        alt_q;
  ps2a_state_t state_q;
  ps2a_state_t state_d;
  logic        emit;
  logic [6:0]  char_d;
  logic        out_free;
  logic        advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= scan_byte_i;
    end
  end

  ps2a_decode u_decode (
    .state_i     (state_q),
    .scan_byte_i (byte_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .char_o      (char_d)
  );

  // Decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      char_q <= char_d;
      ctrl_q <= state_d.mods[ModLCtrl] | state_d.mods[ModRCtrl];
      alt_q  <= state_d.mods[ModLAlt];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign ctrl_held_o = ctrl_q;
  assign alt_held_o  = alt_q;

`ifndef SYNTH
  // Skip count never exceeds the pause length
  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.skip_count <= PauseSkip)
    else $error("skip count out of range");

  // A swallowed byte never yields an output item
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.skip_count != 3'd0) |=> !out_valid_o)
    else $error("output produced for a skipped byte");

  // Output characters are never zero
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> character_o != 7'h00)
    else $error("zero character emitted");
`endif

endmodule

`default_nettype wire
